FILE: rtl/core/csl_pkg.sv
package csl_pkg;

  localparam int CoordBits  = 10;
  localparam int WorkBits   = CoordBits + 2;
  localparam int ProdBits   = 2 * WorkBits;
  localparam int DivCntBits = $clog2(ProdBits + 1);
  localparam int StepBits   = 3;
  localparam int MaxClips   = 4;

  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeTop    = 4'd8;

  localparam logic [1:0] RegXMin = 2'd0;
  localparam logic [1:0] RegYMin = 2'd1;
  localparam logic [1:0] RegXMax = 2'd2;
  localparam logic [1:0] RegYMax = 2'd3;

  typedef struct packed {
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic                 accepted;
    logic [CoordBits-1:0] clip_start_x;
    logic [CoordBits-1:0] clip_start_y;
    logic [CoordBits-1:0] clip_end_x;
    logic [CoordBits-1:0] clip_end_y;
  } out_t;

  typedef struct packed {
    logic [CoordBits-1:0] x_min;
    logic [CoordBits-1:0] y_min;
    logic [CoordBits-1:0] x_max;
    logic [CoordBits-1:0] y_max;
  } win_t;

  typedef struct packed {
    logic [CoordBits-1:0] ax;
    logic [CoordBits-1:0] ay;
    logic [CoordBits-1:0] bx;
    logic [CoordBits-1:0] by;
    logic [3:0]           ca;
    logic [3:0]           cb;
  } job_t;

  function automatic logic [3:0] region_of(input logic signed [WorkBits-1:0] px,
                                           input logic signed [WorkBits-1:0] py,
                                           input win_t w);
    logic [3:0] c;
    c = 4'd0;
    if (px < $signed({2'b00, w.x_min})) c = c | CodeLeft;
    else if (px > $signed({2'b00, w.x_max})) c = c | CodeRight;
    if (py < $signed({2'b00, w.y_min})) c = c | CodeBottom;
    else if (py > $signed({2'b00, w.y_max})) c = c | CodeTop;
    return c;
  endfunction

endpackage

FILE: rtl/core/cohen_sutherland_line_clipper_top.sv
// Cohen-Sutherland line clipper: each in_ beat is one segment, each out_ beat its clipped
// endpoints, or accepted low with all coordinates zero when rejected. The input side
// computes region codes and queues up to two segments; the clip engine takes one segment
// at a time; each clip step runs evaluate, multiply, a sequential restoring divide and
// update. Window registers may only be written while no segment is in flight.
module cohen_sutherland_line_clipper_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  csl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output csl_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [csl_pkg::CoordBits-1:0] cfg_wdata
);

  csl_pkg::win_t win_r, win_nxt;
  csl_pkg::job_t front_job, q_data;
  logic q_full, q_valid, q_pop, in_take;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  always_comb begin
    win_nxt = win_r;
    if (cfg_we) begin
      unique case (cfg_index)
        csl_pkg::RegXMin: win_nxt.x_min = cfg_wdata;
        csl_pkg::RegYMin: win_nxt.y_min = cfg_wdata;
        csl_pkg::RegXMax: win_nxt.x_max = cfg_wdata;
        csl_pkg::RegYMax: win_nxt.y_max = cfg_wdata;
        default: win_nxt = win_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{x_min: 10'd250, y_min: 10'd250, x_max: 10'd450, y_max: 10'd450};
    end else begin
      win_r <= win_nxt;
    end
  end

  csl_front u_front (
    .in_data (in_data),
    .win     (win_r),
    .job     (front_job)
  );

  csl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  csl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/csl_front.sv
module csl_front (
  input  csl_pkg::in_t  in_data,
  input  csl_pkg::win_t win,
  output csl_pkg::job_t job
);

  always_comb begin
    job.ax = in_data.start_x;
    job.ay = in_data.start_y;
    job.bx = in_data.end_x;
    job.by = in_data.end_y;
    job.ca = csl_pkg::region_of($signed({2'b00, in_data.start_x}),
                                $signed({2'b00, in_data.start_y}), win);
    job.cb = csl_pkg::region_of($signed({2'b00, in_data.end_x}),
                                $signed({2'b00, in_data.end_y}), win);
  end

endmodule

FILE: rtl/core/csl_queue.sv
module csl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csl_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output csl_pkg::job_t pop_data
);

  csl_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/csl_back.sv
module csl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  csl_pkg::win_t win,
  input  logic          q_valid,
  input  csl_pkg::job_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output csl_pkg::out_t out_data
);

  localparam int W  = csl_pkg::WorkBits;
  localparam int P  = csl_pkg::ProdBits;
  localparam int CB = csl_pkg::CoordBits;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic signed [W-1:0] ax_r, ay_r, bx_r, by_r, ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic [3:0] ca_r, cb_r, ca_nxt, cb_nxt;
  logic [csl_pkg::StepBits-1:0] steps_r, steps_nxt;
  logic side_a_r, side_a_nxt;
  logic vert_r, vert_nxt;
  logic signed [W-1:0] edge_r, edge_nxt, base_r, base_nxt;
  logic signed [W-1:0] fa_r, fa_nxt, fb_r, fb_nxt, den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic [W-1:0] dmag_r, dmag_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [P-1:0] quo_r, quo_nxt;
  logic [csl_pkg::DivCntBits-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  csl_pkg::out_t out_data_r, out_data_nxt;

  logic [3:0] co;
  logic signed [P-1:0] prod;
  logic [P-1:0] pmag;
  logic [W:0] rem_sh;
  logic ge;
  logic signed [P-1:0] qs;
  logic signed [W-1:0] newc;
  logic signed [W-1:0] nx, ny;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid && !out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    steps_nxt     = steps_r;
    side_a_nxt    = side_a_r;
    vert_nxt      = vert_r;
    edge_nxt      = edge_r;
    base_nxt      = base_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    dmag_nxt      = dmag_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    co            = (ca_r != 4'd0) ? ca_r : cb_r;
    prod          = fa_r * fb_r;
    pmag          = prod[P-1] ? P'(-prod) : P'(prod);
    rem_sh        = {rem_r, quo_r[P-1]};
    ge            = rem_sh >= {1'b0, dmag_r};
    qs            = neg_r ? -$signed(quo_r) : $signed(quo_r);
    newc          = base_r + qs[W-1:0];
    nx            = vert_r ? newc : edge_r;
    ny            = vert_r ? edge_r : newc;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          ax_nxt    = $signed({2'b00, q_data.ax});
          ay_nxt    = $signed({2'b00, q_data.ay});
          bx_nxt    = $signed({2'b00, q_data.bx});
          by_nxt    = $signed({2'b00, q_data.by});
          ca_nxt    = q_data.ca;
          cb_nxt    = q_data.cb;
          steps_nxt = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        vert_nxt   = (co & (csl_pkg::CodeTop | csl_pkg::CodeBottom)) != 4'd0;
        side_a_nxt = ca_r != 4'd0;
        if (vert_nxt) begin
          edge_nxt = (co & csl_pkg::CodeTop) != 4'd0 ? $signed({2'b00, win.y_max})
                                                     : $signed({2'b00, win.y_min});
          den_nxt  = by_r - ay_r;
          fa_nxt   = bx_r - ax_r;
          fb_nxt   = edge_nxt - ay_r;
          base_nxt = ax_r;
        end else begin
          edge_nxt = (co & csl_pkg::CodeRight) != 4'd0 ? $signed({2'b00, win.x_max})
                                                       : $signed({2'b00, win.x_min});
          den_nxt  = bx_r - ax_r;
          fa_nxt   = by_r - ay_r;
          fb_nxt   = edge_nxt - ax_r;
          base_nxt = ay_r;
        end
        if (ca_r == 4'd0 && cb_r == 4'd0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{accepted: 1'b1,
                            clip_start_x: ax_r[CB-1:0], clip_start_y: ay_r[CB-1:0],
                            clip_end_x: bx_r[CB-1:0], clip_end_y: by_r[CB-1:0]};
          state_nxt     = S_IDLE;
        end else if ((ca_r & cb_r) != 4'd0 ||
                     steps_r == csl_pkg::StepBits'(csl_pkg::MaxClips) ||
                     den_nxt == '0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        neg_nxt   = prod[P-1] ^ den_r[W-1];
        dmag_nxt  = den_r[W-1] ? W'(-den_r) : W'(den_r);
        rem_nxt   = '0;
        quo_nxt   = pmag;
        cnt_nxt   = csl_pkg::DivCntBits'(P);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? W'(rem_sh - {1'b0, dmag_r}) : rem_sh[W-1:0];
        quo_nxt = {quo_r[P-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == csl_pkg::DivCntBits'(1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (side_a_r) begin
          ax_nxt = nx;
          ay_nxt = ny;
          ca_nxt = csl_pkg::region_of(nx, ny, win);
        end else begin
          bx_nxt = nx;
          by_nxt = ny;
          cb_nxt = csl_pkg::region_of(nx, ny, win);
        end
        state_nxt = S_EVAL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    steps_r    <= steps_nxt;
    side_a_r   <= side_a_nxt;
    vert_r     <= vert_nxt;
    edge_r     <= edge_nxt;
    base_r     <= base_nxt;
    fa_r       <= fa_nxt;
    fb_r       <= fb_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    dmag_r     <= dmag_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/csl_checker.sv
module csl_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input csl_pkg::out_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.clip_start_x == '0 &&
      out_data.clip_start_y == '0 && out_data.clip_end_x == '0 && out_data.clip_end_y == '0)
    else $error("rejected segment with nonzero coordinates");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cohen_sutherland_line_clipper_top csl_checker u_csl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
